FILE: rtl/grid_cell_box_enumerator_unit_assert.svh
// Assertion macros for the grid cell box enumerator.
`ifndef GRID_CELL_BOX_ENUMERATOR_UNIT_ASSERT_SVH
`define GRID_CELL_BOX_ENUMERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define GCBE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("grid cell box enumerator: property failed");

`define GCBE_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("grid cell box enumerator: forbidden condition seen");

`else

`define GCBE_ASSERT(name, clk, rst, prop)

`define GCBE_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

FILE: rtl/gcbe_pkg.sv
package gcbe_pkg;

  localparam int COORD_W     = 32;
  localparam int OUT_INDEX_W = 6;
  localparam int MAX_RESULTS = 64;
  localparam int CFG_INDEX_W = 3;

  localparam int CELLS_X_DEF = 4;
  localparam int CELLS_Y_DEF = 4;
  localparam int CELLS_Z_DEF = 4;

  localparam logic signed [COORD_W-1:0] GRID_LOW_RST  = 32'sd0;
  localparam logic signed [COORD_W-1:0] GRID_HIGH_RST = 32'sd1048576;

  localparam logic [CFG_INDEX_W-1:0] REG_LOW_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_Y  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_Y = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_Z  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_Z = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_low_x;
    logic signed [COORD_W-1:0] box_high_x;
    logic signed [COORD_W-1:0] box_low_y;
    logic signed [COORD_W-1:0] box_high_y;
    logic signed [COORD_W-1:0] box_low_z;
    logic signed [COORD_W-1:0] box_high_z;
  } box_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] linear_index;
    logic                   last_cell;
    logic                   box_error;
  } cell_t;

endpackage

FILE: rtl/gcbe_divider.sv
`include "grid_cell_box_enumerator_unit_assert.svh"

module gcbe_divider #(
  parameter int QW = 2,
  parameter int CW = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [CW-1:0]                   cells,
  input  logic [gcbe_pkg::COORD_W-1:0]    dividend,
  input  logic [gcbe_pkg::COORD_W-1:0]    divisor,
  output logic                            busy,
  output logic                            done,
  output logic [QW-1:0]                   quotient
);

  localparam int NW    = gcbe_pkg::COORD_W + QW;
  localparam int PW    = gcbe_pkg::COORD_W + CW;
  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

  logic [gcbe_pkg::COORD_W-1:0] dvd;
  logic [gcbe_pkg::COORD_W-1:0] dsr;
  logic [CW-1:0]                cells_r;
  logic                         mul_phase;
  logic [CNT_W-1:0]             count;
  logic [NW-1:0]                rem;
  logic [NW-1:0]                dsh;
  logic [PW-1:0]                prod;
  logic                         ge;

  assign prod = PW'(dvd) * PW'(cells_r);
  assign ge   = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      mul_phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        mul_phase <= 1'b1;
      end else if (busy && mul_phase) begin
        mul_phase <= 1'b0;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= dividend;
      dsr     <= divisor;
      cells_r <= cells;
    end else if (busy && mul_phase) begin
      rem      <= prod[NW-1:0];
      dsh      <= NW'(dsr) << (QW - 1);
      count    <= CNT_W'(QW - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= QW'({quotient, ge});
      dsh      <= dsh >> 1;
      count    <= count - CNT_W'(1);
    end
  end

  `GCBE_ASSERT(a_div_done_ends_busy, clk, rst, done |-> !busy)
  `GCBE_ASSERT(a_div_done_after_busy, clk, rst, done |-> $past(busy))
  `GCBE_ASSERT_NEVER(a_div_start_while_busy, clk, rst, start && busy)

endmodule

FILE: rtl/grid_cell_box_enumerator_unit.sv
// Grid cell box enumerator.
// Input channel box (box_valid / box_stall): one query box per item, six
// Q16.16 coordinates. Output result (cell_valid / cell_stall): one
// covered cell index per item, x fastest, last_cell on the final one; a box
// that is inverted or leaves the grid gives a single item with box_error.
// The user must write grid bounds through cfg_write / cfg_index / cfg_data
// only while idle; the block itself does not enforce it. Each axis is
// checked in turn, then six divisions run on one shared bit-serial divider
// (QW = quotient bits, 2 for a 4x4x4 grid), then the start index is formed.
// A box that fails a check goes straight to its single box_error item.
// Throughput: one cell item per cycle unless stalled, at most 64 per box.
// box_stall is high from acceptance until the last item of that box has been
// loaded into the output register; the next box can enter while that item
// still waits. A stalled cell item holds and the walk pauses.
// Reset: synchronous, clears control, grid bounds return to [0, 16.0).
`include "grid_cell_box_enumerator_unit_assert.svh"

module grid_cell_box_enumerator_unit #(
  parameter int CELLS_X = gcbe_pkg::CELLS_X_DEF,
  parameter int CELLS_Y = gcbe_pkg::CELLS_Y_DEF,
  parameter int CELLS_Z = gcbe_pkg::CELLS_Z_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gcbe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gcbe_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                box_valid,
  output logic                                box_stall,
  input  gcbe_pkg::box_t                      box,
  output logic                                cell_valid,
  input  logic                                cell_stall,
  output gcbe_pkg::cell_t                     result
);

  localparam int CXY_MAX  = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
  localparam int CELL_MAX = (CXY_MAX > CELLS_Z) ? CXY_MAX : CELLS_Z;
  localparam int QW       = (CELL_MAX > 1) ? $clog2(CELL_MAX) : 1;
  localparam int CW       = $clog2(CELL_MAX + 1);
  localparam int IW       = gcbe_pkg::OUT_INDEX_W;

  localparam logic [CW-1:0] CX_C = CW'(CELLS_X);
  localparam logic [CW-1:0] CY_C = CW'(CELLS_Y);
  localparam logic [CW-1:0] CZ_C = CW'(CELLS_Z);

  localparam logic [IW-1:0] ROW_STEP   = IW'(CELLS_X % 64);
  localparam logic [IW-1:0] PLANE_STEP = IW'((CELLS_X * CELLS_Y) % 64);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0] state;
  logic [1:0] axis;
  logic       hsel;

  logic signed [gcbe_pkg::COORD_W-1:0] grid_low  [3];
  logic signed [gcbe_pkg::COORD_W-1:0] grid_high [3];
  logic signed [gcbe_pkg::COORD_W-1:0] box_lo    [3];
  logic signed [gcbe_pkg::COORD_W-1:0] box_hi    [3];

  logic [QW-1:0] first_cell [3];
  logic [QW-1:0] final_cell [3];
  logic [QW-1:0] x_pos;
  logic [QW-1:0] y_pos;
  logic [QW-1:0] z_pos;
  logic [IW-1:0] idx;
  logic [IW-1:0] row_idx;
  logic [IW-1:0] plane_idx;
  logic [IW-1:0] n_out;

  logic signed [gcbe_pkg::COORD_W-1:0] lo_a, hi_a, gl_a, gh_a;
  logic                                bad;
  logic [gcbe_pkg::COORD_W-1:0]        div_dividend;
  logic [gcbe_pkg::COORD_W-1:0]        div_divisor;
  logic [CW-1:0]                       cells_sel;
  logic                                div_start, div_busy, div_done;
  logic [QW-1:0]                       div_q;

  logic          load;
  logic          x_end, y_end, z_end, walk_done;
  logic [QW+IW-1:0] y_prod, z_prod;
  logic [IW-1:0] idx_init;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        grid_low[a]  <= gcbe_pkg::GRID_LOW_RST;
        grid_high[a] <= gcbe_pkg::GRID_HIGH_RST;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        gcbe_pkg::REG_LOW_X:  grid_low[0]  <= cfg_data;
        gcbe_pkg::REG_HIGH_X: grid_high[0] <= cfg_data;
        gcbe_pkg::REG_LOW_Y:  grid_low[1]  <= cfg_data;
        gcbe_pkg::REG_HIGH_Y: grid_high[1] <= cfg_data;
        gcbe_pkg::REG_LOW_Z:  grid_low[2]  <= cfg_data;
        gcbe_pkg::REG_HIGH_Z: grid_high[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lo_a = box_lo[axis];
  assign hi_a = box_hi[axis];
  assign gl_a = grid_low[axis];
  assign gh_a = grid_high[axis];

  assign bad = (gh_a <= gl_a) || (lo_a < gl_a) || (lo_a >= hi_a) || (hi_a >= gh_a);

  // differences are known to lie in [0, 2^32), so 32-bit wrap is exact
  assign div_dividend = hsel ? 32'(hi_a - gl_a) : 32'(lo_a - gl_a);
  assign div_divisor  = 32'(gh_a - gl_a);
  assign div_start    = (state == S_SETUP);

  always_comb begin
    case (axis)
      AXIS_X:  cells_sel = CX_C;
      AXIS_Y:  cells_sel = CY_C;
      default: cells_sel = CZ_C;
    endcase
  end

  gcbe_divider #(
    .QW (QW),
    .CW (CW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .cells    (cells_sel),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign y_prod   = (QW+IW)'(first_cell[1]) * (QW+IW)'(ROW_STEP);
  assign z_prod   = (QW+IW)'(first_cell[2]) * (QW+IW)'(PLANE_STEP);
  assign idx_init = IW'(first_cell[0]) + y_prod[IW-1:0] + z_prod[IW-1:0];

  assign x_end     = (x_pos == final_cell[0]);
  assign y_end     = (y_pos == final_cell[1]);
  assign z_end     = (z_pos == final_cell[2]);
  assign walk_done = (x_end && y_end && z_end) ||
                     (n_out == IW'(gcbe_pkg::MAX_RESULTS - 1));

  assign load      = !cell_valid || !cell_stall;
  assign box_stall = (state != S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      axis       <= AXIS_X;
      hsel       <= 1'b0;
      cell_valid <= 1'b0;
    end else begin
      if (load) begin
        cell_valid <= (state == S_EMIT) || (state == S_ERR);
      end
      case (state)
        S_IDLE: begin
          if (box_valid) begin
            state <= S_CHECK;
            axis  <= AXIS_X;
          end
        end
        S_CHECK: begin
          if (bad) begin
            state <= S_ERR;
          end else if (axis == AXIS_Z) begin
            axis  <= AXIS_X;
            hsel  <= 1'b0;
            state <= S_SETUP;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_SETUP: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (!hsel) begin
              hsel  <= 1'b1;
              state <= S_SETUP;
            end else if (axis == AXIS_Z) begin
              state <= S_INIT;
            end else begin
              axis  <= axis + 2'd1;
              hsel  <= 1'b0;
              state <= S_SETUP;
            end
          end
        end
        S_INIT: state <= S_EMIT;
        S_EMIT: begin
          if (load && walk_done) begin
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && box_valid) begin
      box_lo[0] <= box.box_low_x;
      box_hi[0] <= box.box_high_x;
      box_lo[1] <= box.box_low_y;
      box_hi[1] <= box.box_high_y;
      box_lo[2] <= box.box_low_z;
      box_hi[2] <= box.box_high_z;
    end
    if (state == S_DIV && div_done) begin
      if (hsel) begin
        final_cell[axis] <= div_q;
      end else begin
        first_cell[axis] <= div_q;
      end
    end
    if (state == S_INIT) begin
      x_pos     <= first_cell[0];
      y_pos     <= first_cell[1];
      z_pos     <= first_cell[2];
      idx       <= idx_init;
      row_idx   <= idx_init;
      plane_idx <= idx_init;
      n_out     <= '0;
    end
    if (state == S_EMIT && load) begin
      result.linear_index <= idx;
      result.last_cell    <= walk_done;
      result.box_error    <= 1'b0;
      n_out               <= n_out + IW'(1);
      if (!x_end) begin
        x_pos <= x_pos + QW'(1);
        idx   <= idx + IW'(1);
      end else if (!y_end) begin
        x_pos   <= first_cell[0];
        y_pos   <= y_pos + QW'(1);
        row_idx <= row_idx + ROW_STEP;
        idx     <= row_idx + ROW_STEP;
      end else begin
        x_pos     <= first_cell[0];
        y_pos     <= first_cell[1];
        z_pos     <= z_pos + QW'(1);
        plane_idx <= plane_idx + PLANE_STEP;
        row_idx   <= plane_idx + PLANE_STEP;
        idx       <= plane_idx + PLANE_STEP;
      end
    end
    if (state == S_ERR && load) begin
      result.linear_index <= '0;
      result.last_cell    <= 1'b1;
      result.box_error    <= 1'b1;
    end
  end

  `GCBE_ASSERT(a_err_item_form, clk, rst, cell_valid && result.box_error |-> result.last_cell && result.linear_index == '0)
  `GCBE_ASSERT(a_range_ordered, clk, rst, state == S_INIT |-> first_cell[0] <= final_cell[0] && first_cell[1] <= final_cell[1] && first_cell[2] <= final_cell[2])
  `GCBE_ASSERT(a_walk_in_range, clk, rst, state == S_EMIT |-> x_pos >= first_cell[0] && x_pos <= final_cell[0] && z_pos <= final_cell[2])
  `GCBE_ASSERT(a_stalled_item_holds, clk, rst, cell_valid && cell_stall |=> cell_valid && $stable(result))
  `GCBE_ASSERT(a_div_idle_at_setup, clk, rst, state == S_SETUP |-> !div_busy)

endmodule
